// File: src/ast_pkg.sv
// Shared types and constants of the aging subscriber table.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

  // Opcodes of a request.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // Kinds of a result.
  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_REMOVED  = 3'd2;
  localparam logic [2:0] KIND_EXPIRED  = 3'd3;
  localparam logic [2:0] KIND_COUNT    = 3'd4;

  localparam int unsigned ElapsedWidth = 26;
  localparam int unsigned StepWidth    = 10;
  localparam logic [StepWidth-1:0] STEP_RESET = 10'd100;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [15:0] period_seconds;
  } ast_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] expired_address;
    logic [4:0]  entry_count;
    logic        table_emptied;
    logic        last;
  } ast_out_t;

  typedef struct packed {
    logic [31:0]             address;
    logic [15:0]             period;
    logic [ElapsedWidth-1:0] elapsed;
  } ast_entry_t;

  // Status from the entry unit to the sequencer.
  typedef struct packed {
    logic match;
    logic expired;
  } ast_unit_st_t;

endpackage

`default_nettype wire

// File: src/ast_mem.sv
// Entry store of the subscriber table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ast_mem
  import ast_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxWidth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IdxWidth-1:0] waddr_i,
  input  wire ast_entry_t          wdata_i,
  input  wire logic [IdxWidth-1:0] raddr_i,
  output ast_entry_t               rdata_o
);

  ast_entry_t mem [Depth];
  ast_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/ast_unit.sv
// Entry unit, applied to each entry read in turn: address compare, timer advance and lease limit compare.
`timescale 1ns / 1ps
`default_nettype none

module ast_unit
  import ast_pkg::*;
(
  input  wire ast_entry_t             entry_i,
  input  wire logic [31:0]            key_i,
  input  wire logic [StepWidth-1:0]   step_i,
  output logic [ElapsedWidth-1:0]     elapsed_o,
  output ast_unit_st_t                st_o
);

  logic [ElapsedWidth-1:0] limit;
  logic [ElapsedWidth-1:0] p_ext;

  // The limit is period * 1000, built as p*1024 - p*16 - p*8.
  assign p_ext     = ElapsedWidth'(entry_i.period);
  assign limit     = (p_ext << 10) - (p_ext << 4) - (p_ext << 3);
  assign elapsed_o = entry_i.elapsed + ElapsedWidth'(step_i);

  assign st_o.match   = (entry_i.address == key_i);
  assign st_o.expired = (elapsed_o >= limit);

endmodule

`default_nettype wire

// File: src/aging_subscriber_table_top.sv
// Top level of the aging subscriber table: sequencer, result buffer, configuration.
// Add and remove read and evaluate one entry after another (RD, EVAL) up to a match or
// the end; query goes straight to its result. A tick visits every live entry, with EXP
// per expiry, preceded by MOVE unless the tail expired, as the entry store has one read port.
// One request is worked on at a time; ready is low while a request is in progress.
// Reset (asynchronous, active low) empties the table and sets the tick step to 100.
`timescale 1ns / 1ps
`default_nettype none

module aging_subscriber_table_top
  import ast_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ast_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ast_out_t                  out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [StepWidth-1:0] cfg_data_i
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // The sequencer walks the table one entry at a time. RD issues the read of
  // the current slot, EVAL decides on the entry, MOVE copies the tail entry
  // into a freed slot, EXP queues an expiry, FLUSH releases the last queued
  // expiry and OUT delivers the single result of add, remove or query.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_MOVE  = 7'b0001000,
    S_EXP   = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       tail;
  logic [StepWidth-1:0] step_q;
  logic [1:0]          op_q, op_d;
  logic [31:0]         key_q, key_d;
  logic [15:0]         period_q, period_d;
  logic [2:0]          kind_q, kind_d;
  logic [31:0]         gone_q, gone_d;

  // Expiries are held back by one so that the last flag can be set once the
  // walk is known to be over.
  ast_out_t            pend_q, pend_d;
  logic                pend_valid_q, pend_valid_d;
  ast_out_t            out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  ast_entry_t          mem_wdata;
  logic [IW-1:0]       mem_raddr;
  ast_entry_t          mem_rdata;
  logic [ElapsedWidth-1:0] new_elapsed;
  ast_unit_st_t        unit_st;

  ast_mem #(
    .Depth    (TABLE_DEPTH),
    .IdxWidth (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ast_unit u_unit (
    .entry_i   (mem_rdata),
    .key_i     (key_q),
    .step_i    (step_q),
    .elapsed_o (new_elapsed),
    .st_o      (unit_st)
  );

  assign tail        = count_q - CW'(1);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The result register can take a new result when it is empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    op_d         = op_q;
    key_d        = key_q;
    period_d     = period_q;
    kind_d       = kind_q;
    gone_d       = gone_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[IW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = idx_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i.opcode;
          key_d    = in_data_i.address;
          period_d = in_data_i.period_seconds;
          idx_d    = '0;
          if (in_data_i.opcode == OP_QUERY) begin
            kind_d  = KIND_COUNT;
            state_d = S_OUT;
          end else if (in_data_i.opcode == OP_ADD && count_q >= CW'(TABLE_DEPTH)) begin
            kind_d  = KIND_REJECTED;
            state_d = S_OUT;
          end else if (in_data_i.opcode == OP_TICK && count_q == '0) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q == count_q) begin
          // Walk finished without an early exit.
          case (op_q)
            OP_ADD: begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IW-1:0];
              mem_wdata = '{address: key_q, period: period_q, elapsed: '0};
              count_d   = count_q + CW'(1);
              kind_d    = KIND_ADDED;
              state_d   = S_OUT;
            end
            OP_REMOVE: begin
              kind_d  = KIND_REMOVED;
              state_d = S_OUT;
            end
            default: begin
              state_d = pend_valid_q ? S_FLUSH : S_IDLE;
            end
          endcase
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        mem_raddr = tail[IW-1:0];
        case (op_q)
          OP_ADD: begin
            if (unit_st.match) begin
              kind_d  = KIND_REJECTED;
              state_d = S_OUT;
            end else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_RD;
            end
          end
          OP_REMOVE: begin
            if (unit_st.match) begin
              kind_d = KIND_REMOVED;
              if (idx_q == tail) begin
                count_d = tail;
                state_d = S_OUT;
              end else begin
                state_d = S_MOVE;
              end
            end else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_RD;
            end
          end
          default: begin
            if (unit_st.expired) begin
              gone_d = mem_rdata.address;
              if (idx_q == tail) begin
                count_d = tail;
                state_d = S_EXP;
              end else begin
                state_d = S_MOVE;
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{address: mem_rdata.address, period: mem_rdata.period,
                            elapsed: new_elapsed};
              idx_d     = idx_q + CW'(1);
              state_d   = S_RD;
            end
          end
        endcase
      end
      S_MOVE: begin
        // The tail entry fills the freed slot; in a tick it is examined next,
        // since the slot index is left where it is.
        mem_we  = 1'b1;
        count_d = tail;
        state_d = (op_q == OP_REMOVE) ? S_OUT : S_EXP;
      end
      S_EXP: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_valid_d = 1'b1;
          end
          pend_d.kind            = KIND_EXPIRED;
          pend_d.expired_address = gone_q;
          pend_d.entry_count     = 5'(count_q);
          pend_d.table_emptied   = (count_q == '0);
          pend_d.last            = 1'b0;
          pend_valid_d           = 1'b1;
          state_d                = S_RD;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_d        = pend_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d.kind            = kind_q;
          out_d.expired_address = '0;
          out_d.entry_count     = 5'(count_q);
          out_d.table_emptied   = 1'b0;
          out_d.last            = 1'b1;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      op_q         <= OP_QUERY;
      kind_q       <= KIND_COUNT;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= STEP_RESET;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      op_q         <= op_d;
      kind_q       <= kind_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    period_q <= period_d;
    gone_q   <= gone_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// File: sim/ast_table_checker.sv
// Checker that predicts the subscriber table's results and compares them with the outputs.
`timescale 1ns / 1ps

module ast_table_checker
  import ast_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  ast_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  ast_out_t             out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [StepWidth-1:0] cfg_data_i,
  input  logic                 end_check_i,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          fail_count_o
);

  localparam int unsigned MaxPrinted = 30;

  // Shadow copy of the table and of the tick step.
  logic [31:0]             slot_address [TABLE_DEPTH];
  logic [15:0]             slot_period  [TABLE_DEPTH];
  logic [ElapsedWidth-1:0] slot_elapsed [TABLE_DEPTH];
  int unsigned             live_count;
  logic [StepWidth-1:0]    step_ms;

  ast_out_t    awaited_results [$];
  ast_out_t    want;
  int unsigned errors;
  int unsigned compared;
  bit          leftover_checked;

  task automatic report_mismatch(input string what);
    // Only the first few are printed so that a broken design cannot flood the log.
    if (errors < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  function automatic ast_out_t make_result(input logic [2:0] kind, input logic [31:0] addr,
                                           input logic emptied, input logic last);
    ast_out_t r;
    r.kind            = kind;
    r.expired_address = addr;
    r.entry_count     = live_count[4:0];
    r.table_emptied   = emptied;
    r.last            = last;
    return r;
  endfunction

  // Removal by moving the last entry into the freed slot.
  task automatic drop_slot(input int unsigned idx);
    int unsigned tail;
    tail = live_count - 1;
    slot_address[idx] = slot_address[tail];
    slot_period[idx]  = slot_period[tail];
    slot_elapsed[idx] = slot_elapsed[tail];
    live_count        = tail;
  endtask

  task automatic predict_table_response(input ast_in_t req);
    bit          rejected;
    bit          found;
    bit          have_held;
    ast_out_t    held;
    logic [31:0] gone;
    int unsigned idx;
    case (req.opcode)
      OP_ADD: begin
        rejected = (live_count >= TABLE_DEPTH);
        for (idx = 0; idx < live_count; idx++) begin
          if (slot_address[idx] == req.address) rejected = 1'b1;
        end
        if (rejected) begin
          awaited_results.push_back(make_result(KIND_REJECTED, '0, 1'b0, 1'b1));
        end else begin
          slot_address[live_count] = req.address;
          slot_period[live_count]  = req.period_seconds;
          slot_elapsed[live_count] = '0;
          live_count++;
          awaited_results.push_back(make_result(KIND_ADDED, '0, 1'b0, 1'b1));
        end
      end
      OP_REMOVE: begin
        found = 1'b0;
        for (idx = 0; idx < live_count && !found; idx++) begin
          if (slot_address[idx] == req.address) begin
            drop_slot(idx);
            found = 1'b1;
          end
        end
        awaited_results.push_back(make_result(KIND_REMOVED, '0, 1'b0, 1'b1));
      end
      OP_QUERY: begin
        awaited_results.push_back(make_result(KIND_COUNT, '0, 1'b0, 1'b1));
      end
      default: begin
        // Each expiry is held back one step so the final one can carry last.
        have_held = 1'b0;
        idx = 0;
        while (idx < live_count) begin
          slot_elapsed[idx] = slot_elapsed[idx] + {16'd0, step_ms};
          if ({6'd0, slot_elapsed[idx]} >= {16'd0, slot_period[idx]} * 32'd1000) begin
            gone = slot_address[idx];
            drop_slot(idx);
            if (have_held) awaited_results.push_back(held);
            held = make_result(KIND_EXPIRED, gone, live_count == 0, 1'b0);
            have_held = 1'b1;
          end else begin
            idx++;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_count = 0;
      step_ms    = STEP_RESET;
      awaited_results.delete();
      errors           = 0;
      compared         = 0;
      leftover_checked = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) step_ms = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_table_response(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, kind %0d count %0d",
                                    out_data_i.kind, out_data_i.entry_count));
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (out_data_i.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_data_i.kind, want.kind));
          if (out_data_i.expired_address !== want.expired_address)
            report_mismatch($sformatf("expired_address %h, expected %h",
                                      out_data_i.expired_address, want.expired_address));
          if (out_data_i.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_data_i.entry_count, want.entry_count));
          if (out_data_i.table_emptied !== want.table_emptied)
            report_mismatch($sformatf("table_emptied %b, expected %b",
                                      out_data_i.table_emptied, want.table_emptied));
          if (out_data_i.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_data_i.last, want.last));
        end
      end
      if (end_check_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (awaited_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      end
    end
    pending_o    <= awaited_results.size();
    checked_o    <= compared;
    fail_count_o <= errors;
  end

endmodule

// File: sim/tb.sv
// Testbench top of the aging subscriber table: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb;
  import ast_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  // A tick that finds no expiry gives no result, so after the last result the block may
  // still be walking the table; the settle time covers that walk with margin.
  localparam int unsigned SettleCycles = 100;
  // The slowest correct run stays far below this, even with every result stalled.
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned PhaseItems = 12;
  localparam int unsigned PoolSize = 20;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ast_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ast_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [StepWidth-1:0] cfg_data = '0;
  logic                 end_check = 1'b0;

  int unsigned pending;
  int unsigned checked;
  int unsigned fail_count;
  int unsigned cycles = 0;
  int unsigned sent_by_op [4];
  int unsigned step_writes = 0;

  // Addresses are mostly drawn from a small pool so that duplicates and hits on
  // remove happen often; the rest are fully random.
  logic [31:0] address_pool [PoolSize];

  always #5ns clk = ~clk;

  aging_subscriber_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  ast_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .end_check_i (end_check),
    .pending_o   (pending),
    .checked_o   (checked),
    .fail_count_o(fail_count)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it was accepted. Valid is
  // left high, so a back-to-back request never drops it.
  task automatic send_request(input ast_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_by_op[req.opcode]++;
  endtask

  // Random gap after a request: mostly none or short, now and then long.
  task automatic idle_sender();
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    if (pick < 50) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 80);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [1:0] op, input logic [31:0] addr, input logic [15:0] period);
    ast_in_t req;
    req.opcode         = op;
    req.address        = addr;
    req.period_seconds = period;
    send_request(req);
    idle_sender();
  endtask

  // The sender stops until every predicted result has come back, then gives a
  // tick that is still walking the table time to finish.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The step register may only change while the table is idle.
  task automatic write_tick_step(input logic [StepWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    step_writes++;
  endtask

  function automatic ast_in_t random_request();
    ast_in_t     req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) req.opcode = OP_ADD;
    else if (pick < 55) req.opcode = OP_REMOVE;
    else if (pick < 85) req.opcode = OP_TICK;
    else req.opcode = OP_QUERY;
    if ($urandom_range(0, 9) < 7) req.address = address_pool[$urandom_range(0, PoolSize - 1)];
    else req.address = $urandom;
    // Short leases keep expiries frequent; a few full-range periods exercise the
    // wide compare and the upper bits.
    pick = $urandom_range(0, 9);
    if (pick < 7) req.period_seconds = 16'($urandom_range(0, 3));
    else if (pick < 9) req.period_seconds = 16'($urandom_range(4, 20));
    else req.period_seconds = 16'($urandom);
    return req;
  endfunction

  // Receiver: random ready patterns, plus one long hold-off once traffic is
  // flowing, so that the result buffer fills and the input side stalls.
  initial begin : receiver
    int unsigned pick;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (!long_hold_done && checked >= 40) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end else if (pick < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (pick < 92) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [StepWidth-1:0] phase_steps [6];
    int unsigned          ph;
    int unsigned          k;

    for (k = 0; k < 4; k++) sent_by_op[k] = 0;
    address_pool[0] = 32'h0000_0000;
    address_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < PoolSize; k++) address_pool[k] = $urandom;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset step of 100 ms. The widest address with the
    // longest lease, then a zero lease that must expire on the very next tick,
    // a duplicate add, a query, a remove that misses and one that hits, and a
    // tick on an empty table, which returns nothing.
    issue(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    issue(OP_ADD, 32'h0000_0000, 16'h0000);
    issue(OP_ADD, 32'h0000_0000, 16'h0005);
    issue(OP_QUERY, 32'h1234_5678, 16'h00FF);
    issue(OP_TICK, 32'h0, 16'h0);
    issue(OP_REMOVE, 32'h0001_2345, 16'h0);
    issue(OP_REMOVE, 32'hFFFF_FFFF, 16'h0);
    issue(OP_TICK, 32'h0, 16'h0);

    // Fill the table, then one more add that the full table must reject.
    for (k = 0; k < TABLE_DEPTH; k++) begin
      issue(OP_ADD, 32'hA5A5_0000 | k, (k % 2 == 0) ? 16'd1 : 16'd2);
    end
    issue(OP_ADD, 32'h5A5A_5A5A, 16'd1);

    // With a one-second step every one-second lease goes at once, including the
    // entries moved into freed slots; the next tick empties the table.
    wait_until_drained();
    write_tick_step(10'd1000);
    issue(OP_TICK, 32'h0, 16'h0);
    issue(OP_TICK, 32'h0, 16'h0);

    // Random part over several step settings, both ends of the register among them.
    phase_steps[0] = 10'd1;
    phase_steps[1] = 10'd0;
    phase_steps[2] = 10'd1023;
    phase_steps[3] = StepWidth'($urandom_range(2, 999));
    phase_steps[4] = 10'd1000;
    phase_steps[5] = STEP_RESET;
    for (ph = 0; ph < 6; ph++) begin
      wait_until_drained();
      write_tick_step(phase_steps[ph]);
      for (k = 0; k < PhaseItems; k++) begin
        send_request(random_request());
        idle_sender();
      end
    end

    wait_until_drained();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d adds, %0d removes, %0d ticks and %0d queries over %0d step writes.",
             sent_by_op[OP_ADD], sent_by_op[OP_REMOVE], sent_by_op[OP_TICK],
             sent_by_op[OP_QUERY], step_writes);
    $display("%0d results compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/ast_pkg.sv
src/ast_mem.sv
src/ast_unit.sv
src/aging_subscriber_table_top.sv
sim/ast_table_checker.sv
sim/tb.sv
